// ===== hdl/sv39pm_pkg.sv =====
// Sv39 page-map insert: shared types and constants.
// Used by sv39pm_ctrl, sv39pm_dp and the top level sv39_page_map_insert.
package sv39pm_pkg;

    localparam int VA_W     = 64;
    localparam int PA_W     = 56;
    localparam int PPN_W    = 44;
    localparam int PTE_W    = 64;
    localparam int VPN_W    = 9;
    localparam int USED_W   = 5;
    localparam int FLAG_W   = 10;

    localparam logic [FLAG_W-1:0] PTR_FLAGS  = 10'h011;
    localparam logic [FLAG_W-1:0] LEAF_FLAGS = 10'h01F;
    localparam logic [PPN_W-1:0]  BASE_RESET = 44'd524288;

    typedef enum logic [1:0] {
        ST_MAPPED    = 2'd0,
        ST_NONCANON  = 2'd1,
        ST_EXHAUSTED = 2'd2
    } st_code_t;

    // controller -> datapath
    typedef struct packed {
        logic     clear;
        logic     take;
        logic     rd_mid;
        logic     eval_root;
        logic     eval_mid;
        logic     plan;
        logic     sweep;
        logic     sweep_leaf;
        logic     wr_root;
        logic     wr_mid;
        logic     wr_leaf;
        logic     set_res;
        st_code_t res_code;
        logic     load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic noncanon;
        logic entry_valid;
        logic stray;
        logic new_mid;
        logic new_leaf;
        logic no_room;
        logic dirty;
        logic sweep_last;
        logic out_free;
    } stat_t;

endpackage

// ===== hdl/sv39_page_map_insert.sv =====
// Sv39 page-map insert: top level joining the sequencer and the datapath.
// Depends on sv39pm_pkg, sv39pm_ctrl and sv39pm_dp.
//
//  channel  signals                                       transfer
//  req      req_valid/req_ready, virt_addr, phys_addr     valid & ready
//  rsp      rsp_valid/rsp_ready, status, leaf_entry,      valid & ready
//           pages_used
//  cfg      cfg_wr_en, cfg_wr_data (pool_base_page)       cfg_wr_en
//
// One request at a time: req_ready is high only while idle. A walk that hits makes
// two dependent reads of the table store.
// Once a pointer has led into an unallocated page, each freshly allocated page is
// zeroed first, entry by entry.
// After reset the whole store is cleared, with req_ready low.
// A result held by rsp_ready low does not block the next request transfer.
module sv39_page_map_insert
    import sv39pm_pkg::*;
#(
    parameter int TABLE_PAGES = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [PPN_W-1:0]    cfg_wr_data,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [VA_W-1:0]     virt_addr,
    input  logic [PA_W-1:0]     phys_addr,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [1:0]          status,
    output logic [PTE_W-1:0]    leaf_entry,
    output logic [USED_W-1:0]   pages_used
);

    cmd_t  cmd;
    stat_t stat;

    sv39pm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sv39pm_dp #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .virt_addr   (virt_addr),
        .phys_addr   (phys_addr),
        .cmd         (cmd),
        .stat        (stat),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .leaf_entry  (leaf_entry),
        .pages_used  (pages_used)
    );

endmodule

// ===== hdl/sv39pm_ctrl.sv =====
// Sv39 page-map insert: walk and commit sequencer.
// Depends on sv39pm_pkg (cmd_t, stat_t, st_code_t).
module sv39pm_ctrl
    import sv39pm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [11:0] {
        S_CLEAR  = 12'b0000_0000_0001,
        S_IDLE   = 12'b0000_0000_0010,
        S_CHECK  = 12'b0000_0000_0100,
        S_ROOT   = 12'b0000_0000_1000,
        S_MID    = 12'b0000_0001_0000,
        S_PLAN   = 12'b0000_0010_0000,
        S_ZMID   = 12'b0000_0100_0000,
        S_WROOT  = 12'b0000_1000_0000,
        S_ZLEAF  = 12'b0001_0000_0000,
        S_WMID   = 12'b0010_0000_0000,
        S_WLEAF  = 12'b0100_0000_0000,
        S_RESULT = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        req_ready  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.noncanon)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_NONCANON;
                    state_next   = S_RESULT;
                end
                else
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                cmd.eval_root = 1'b1;
                cmd.rd_mid    = 1'b1;
                if (!stat.entry_valid)
                begin
                    state_next = S_PLAN;
                end
                else if (stat.stray)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_EXHAUSTED;
                    state_next   = S_RESULT;
                end
                else
                begin
                    state_next = S_MID;
                end
            end
            S_MID:
            begin
                cmd.eval_mid = 1'b1;
                if (stat.entry_valid && stat.stray)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_EXHAUSTED;
                    state_next   = S_RESULT;
                end
                else
                begin
                    state_next = S_PLAN;
                end
            end
            S_PLAN:
            begin
                cmd.plan = 1'b1;
                if (stat.no_room)
                begin
                    cmd.set_res  = 1'b1;
                    cmd.res_code = ST_EXHAUSTED;
                    state_next   = S_RESULT;
                end
                else if (stat.new_mid)
                begin
                    state_next = S_ZMID;
                end
                else if (stat.new_leaf)
                begin
                    state_next = S_ZLEAF;
                end
                else
                begin
                    state_next = S_WLEAF;
                end
            end
            S_ZMID:
            begin
                cmd.sweep = stat.dirty;
                if (!stat.dirty || stat.sweep_last)
                begin
                    state_next = S_WROOT;
                end
            end
            S_WROOT:
            begin
                cmd.wr_root = 1'b1;
                state_next  = S_ZLEAF;
            end
            S_ZLEAF:
            begin
                cmd.sweep      = stat.dirty;
                cmd.sweep_leaf = 1'b1;
                if (!stat.dirty || stat.sweep_last)
                begin
                    state_next = S_WMID;
                end
            end
            S_WMID:
            begin
                cmd.wr_mid = 1'b1;
                state_next = S_WLEAF;
            end
            S_WLEAF:
            begin
                cmd.wr_leaf  = 1'b1;
                cmd.set_res  = 1'b1;
                cmd.res_code = ST_MAPPED;
                state_next   = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== hdl/sv39pm_dp.sv =====
// Sv39 page-map insert: table store, allocator, walk registers and result register.
// Depends on sv39pm_pkg; driven by sv39pm_ctrl through cmd_t and stat_t.
module sv39pm_dp
    import sv39pm_pkg::*;
#(
    parameter int TABLE_PAGES = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [PPN_W-1:0]    cfg_wr_data,
    input  logic [VA_W-1:0]     virt_addr,
    input  logic [PA_W-1:0]     phys_addr,
    input  cmd_t                cmd,
    output stat_t               stat,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [1:0]          status,
    output logic [PTE_W-1:0]    leaf_entry,
    output logic [USED_W-1:0]   pages_used
);

    localparam int PW    = $clog2(TABLE_PAGES);
    localparam int NW    = $clog2(TABLE_PAGES + 1);
    localparam int AW    = PW + VPN_W;
    localparam int DEPTH = TABLE_PAGES * (1 << VPN_W);

    logic [PTE_W-1:0]  mem [DEPTH];
    logic [PTE_W-1:0]  rdata_reg;

    logic [PPN_W-1:0]  base_reg;
    logic [VA_W-1:0]   va_reg;
    logic [PA_W-1:0]   pa_reg;
    logic [NW-1:0]     nf_reg;
    logic [NW-1:0]     nf_next;
    logic              dirty_reg;
    logic [PW-1:0]     mid_reg;
    logic [PW-1:0]     leaf_reg;
    logic              new_mid_reg;
    logic              new_leaf_reg;
    logic [AW-1:0]     cnt_reg;
    st_code_t          res_code_reg;
    logic [PTE_W-1:0]  res_leaf_reg;
    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [PTE_W-1:0]  leaf_entry_reg;
    logic [USED_W-1:0] pages_used_reg;

    logic [VPN_W-1:0]  vpn0;
    logic [VPN_W-1:0]  vpn1;
    logic [VPN_W-1:0]  vpn2;
    logic [PPN_W-1:0]  rel;
    logic [PW-1:0]     rel_pg;
    logic              stray;
    logic              unalloc;
    logic [NW:0]       need_sum;
    logic              no_room;
    logic [NW-1:0]     nf_plus1;
    logic [PTE_W-1:0]  leaf_val;
    logic [PTE_W-1:0]  ptr_mid;
    logic [PTE_W-1:0]  ptr_leaf;
    logic [PPN_W-1:0]  ppn_mid;
    logic [PPN_W-1:0]  ppn_leaf;
    logic [PW-1:0]     sweep_pg;
    logic              sweep_last;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [PTE_W-1:0]  mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [NW+USED_W-1:0] nf_ext;

    assign vpn0 = va_reg[20:12];
    assign vpn1 = va_reg[29:21];
    assign vpn2 = va_reg[38:30];

    assign rel     = rdata_reg[53:10] - base_reg;
    assign rel_pg  = rel[PW-1:0];
    assign stray   = rel >= PPN_W'(TABLE_PAGES);
    assign unalloc = NW'(rel_pg) >= nf_reg;

    assign need_sum = {1'b0, nf_reg} + (NW+1)'(new_mid_reg) + (NW+1)'(new_leaf_reg);
    assign no_room  = need_sum > (NW+1)'(TABLE_PAGES);
    assign nf_plus1 = nf_reg + NW'(1);

    assign ppn_mid  = base_reg + PPN_W'(mid_reg);
    assign ppn_leaf = base_reg + PPN_W'(leaf_reg);
    assign ptr_mid  = {10'd0, ppn_mid, PTR_FLAGS};
    assign ptr_leaf = {10'd0, ppn_leaf, PTR_FLAGS};
    assign leaf_val = {10'd0, pa_reg[55:12], LEAF_FLAGS};

    assign sweep_pg   = cmd.sweep_leaf ? leaf_reg : mid_reg;
    assign sweep_last = cnt_reg[VPN_W-1:0] == {VPN_W{1'b1}};

    // single write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg;
        mem_wdata = '0;
        if (cmd.clear)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.sweep)
        begin
            mem_we    = 1'b1;
            mem_waddr = {sweep_pg, cnt_reg[VPN_W-1:0]};
        end
        else if (cmd.wr_root)
        begin
            mem_we    = 1'b1;
            mem_waddr = {{PW{1'b0}}, vpn2};
            mem_wdata = ptr_mid;
        end
        else if (cmd.wr_mid)
        begin
            mem_we    = 1'b1;
            mem_waddr = {mid_reg, vpn1};
            mem_wdata = ptr_leaf;
        end
        else if (cmd.wr_leaf)
        begin
            mem_we    = 1'b1;
            mem_waddr = {leaf_reg, vpn0};
            mem_wdata = leaf_val;
        end
    end

    assign mem_raddr = cmd.rd_mid ? {rel_pg, vpn1} : {{PW{1'b0}}, vpn2};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            va_reg <= virt_addr;
            pa_reg <= phys_addr;
        end
        if (cmd.eval_root)
        begin
            new_mid_reg  <= !rdata_reg[0];
            new_leaf_reg <= !rdata_reg[0];
            mid_reg      <= rel_pg;
        end
        if (cmd.eval_mid)
        begin
            new_leaf_reg <= !rdata_reg[0];
            leaf_reg     <= rel_pg;
        end
        if (cmd.plan && !no_room)
        begin
            if (new_mid_reg)
            begin
                mid_reg  <= nf_reg[PW-1:0];
                leaf_reg <= nf_plus1[PW-1:0];
            end
            else if (new_leaf_reg)
            begin
                leaf_reg <= nf_reg[PW-1:0];
            end
        end
        if (cmd.set_res)
        begin
            res_code_reg <= cmd.res_code;
            res_leaf_reg <= (cmd.res_code == ST_MAPPED) ? leaf_val : '0;
        end
        if (cmd.load_out)
        begin
            status_reg     <= res_code_reg;
            leaf_entry_reg <= res_leaf_reg;
            pages_used_reg <= nf_ext[USED_W-1:0];
        end
    end

    assign nf_next = (cmd.plan && !no_room) ? need_sum[NW-1:0] : nf_reg;
    assign nf_ext  = {{USED_W{1'b0}}, nf_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= BASE_RESET;
            nf_reg        <= NW'(1);
            dirty_reg     <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                base_reg <= cfg_wr_data;
            end
            nf_reg <= nf_next;
            // a pointer followed into a page not yet handed out may leave stale entries there
            if ((cmd.eval_root || cmd.eval_mid) && rdata_reg[0] && !stray && unalloc)
            begin
                dirty_reg <= 1'b1;
            end
            if (cmd.clear)
            begin
                cnt_reg <= stat.clear_last ? '0 : cnt_reg + AW'(1);
            end
            else if (cmd.sweep)
            begin
                cnt_reg <= sweep_last ? '0 : cnt_reg + AW'(1);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat             = '0;
        stat.clear_last  = cnt_reg == AW'(DEPTH - 1);
        stat.noncanon    = va_reg[63:38] != {26{va_reg[38]}};
        stat.entry_valid = rdata_reg[0];
        stat.stray       = stray;
        stat.new_mid     = new_mid_reg;
        stat.new_leaf    = new_leaf_reg;
        stat.no_room     = no_room;
        stat.dirty       = dirty_reg;
        stat.sweep_last  = sweep_last;
        stat.out_free    = !out_valid_reg || rsp_ready;
    end

    assign rsp_valid  = out_valid_reg;
    assign status     = status_reg;
    assign leaf_entry = leaf_entry_reg;
    assign pages_used = pages_used_reg;

`ifndef NO_ASSERTIONS
    a_nf_range: assert property (@(posedge clk) disable iff (!rst_n)
        (nf_reg >= NW'(1)) && (NW'(TABLE_PAGES) >= nf_reg))
        else $error("allocator count out of range");

    a_nf_plan_only: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.plan |=> $stable(nf_reg))
        else $error("allocator moved outside planning");

    a_leaf_canon: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_leaf |-> !stat.noncanon)
        else $error("leaf written for non-canonical address");

    a_mapped_flags: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_MAPPED) |-> leaf_entry[FLAG_W-1:0] == LEAF_FLAGS)
        else $error("mapped result without leaf flags");
`endif

endmodule

// ===== bench/sv39_page_map_insert_test.sv =====
// Testbench for sv39_page_map_insert: address pairs in, mapping results checked
// against a built-in page table walker, with a rewritable pool base.
// Depends on sv39pm_pkg and the sv39_page_map_insert RTL only.
`timescale 1ns / 1ps

module sv39_page_map_insert_test;
    import sv39pm_pkg::*;

    localparam int TABLE_PAGES  = 16;
    localparam int PT_ENTRIES   = 512;
    localparam int QUIET_LIMIT  = 40000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        st_code_t            code;
        logic [PTE_W-1:0]    leaf;
        logic [USED_W-1:0]   used;
    } map_rsp_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [PPN_W-1:0]    cfg_wr_data = '0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    logic [VA_W-1:0]     virt_addr = '0;
    logic [PA_W-1:0]     phys_addr = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    logic [1:0]          status;
    logic [PTE_W-1:0]    leaf_entry;
    logic [USED_W-1:0]   pages_used;

    // shadow page tables
    logic [PTE_W-1:0]    table_mem [TABLE_PAGES*PT_ENTRIES];
    int unsigned         pages_taken;
    logic [PPN_W-1:0]    pool_base;

    map_rsp_t            expected_maps [$];
    logic [VA_W-1:0]     mapped_vas [$];
    int                  errors = 0;
    int                  hold_cycles = 0;
    bit                  req_steady = 1'b0;
    bit                  rsp_steady = 1'b0;

    sv39_page_map_insert #(.TABLE_PAGES(TABLE_PAGES)) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .virt_addr   (virt_addr),
        .phys_addr   (phys_addr),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .status      (status),
        .leaf_entry  (leaf_entry),
        .pages_used  (pages_used)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic bit is_canonical(input logic [VA_W-1:0] va);
        return (&va[63:38]) || !(|va[63:38]);
    endfunction

    function automatic logic [VA_W-1:0] canonical_va(input logic [38:0] low);
        return {{25{low[38]}}, low};
    endfunction

    function automatic void clear_table_page(input int unsigned pg);
        for (int i = 0; i < PT_ENTRIES; i++)
            table_mem[pg*PT_ENTRIES + i] = '0;
    endfunction

    function automatic logic [PTE_W-1:0] table_pointer(input int unsigned pg);
        return {10'd0, pool_base + PPN_W'(pg), PTR_FLAGS};
    endfunction

    // Plans the three-level walk first; only commits if every check passes.
    function automatic map_rsp_t walk_and_map(input logic [VA_W-1:0] va,
                                              input logic [PA_W-1:0] pa);
        map_rsp_t         r;
        logic [PTE_W-1:0] e;
        logic [PPN_W-1:0] rel;
        int unsigned      mid_pg;
        int unsigned      leaf_pg;
        int unsigned      need;
        bit               new_mid;
        bit               new_leaf;
        bit               stray;
        mid_pg  = 0;
        leaf_pg = 0;
        stray   = 1'b0;
        r.code  = ST_MAPPED;
        r.leaf  = '0;
        if (!is_canonical(va))
        begin
            r.code = ST_NONCANON;
        end
        else
        begin
            e = table_mem[va[38:30]];
            new_mid = !e[0];
            if (!new_mid)
            begin
                rel = e[53:10] - pool_base;
                if (rel >= TABLE_PAGES)
                    stray = 1'b1;
                else
                    mid_pg = 32'(rel);
            end
            new_leaf = new_mid;
            if (!new_mid && !stray)
            begin
                e = table_mem[mid_pg*PT_ENTRIES + va[29:21]];
                new_leaf = !e[0];
                if (!new_leaf)
                begin
                    rel = e[53:10] - pool_base;
                    if (rel >= TABLE_PAGES)
                        stray = 1'b1;
                    else
                        leaf_pg = 32'(rel);
                end
            end
            need = int'(new_mid) + int'(new_leaf);
            if (stray || pages_taken + need > TABLE_PAGES)
            begin
                r.code = ST_EXHAUSTED;
            end
            else
            begin
                if (new_mid)
                begin
                    mid_pg = pages_taken++;
                    clear_table_page(mid_pg);
                    table_mem[va[38:30]] = table_pointer(mid_pg);
                end
                if (new_leaf)
                begin
                    leaf_pg = pages_taken++;
                    clear_table_page(leaf_pg);
                    table_mem[mid_pg*PT_ENTRIES + va[29:21]] = table_pointer(leaf_pg);
                end
                r.leaf = {10'd0, pa[55:12], LEAF_FLAGS};
                table_mem[leaf_pg*PT_ENTRIES + va[20:12]] = r.leaf;
            end
        end
        r.used = USED_W'(pages_taken);
        return r;
    endfunction

    task automatic send_map(input logic [VA_W-1:0] va, input logic [PA_W-1:0] pa);
        int       gap;
        map_rsp_t r;
        gap = req_steady ? 0 : $urandom_range(0, 19);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        virt_addr <= va;
        phys_addr <= pa;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        r = walk_and_map(va, pa);
        expected_maps.push_back(r);
        if (r.code == ST_MAPPED)
            mapped_vas.push_back(va);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_maps.size() != 0) @(posedge clk);
    endtask

    task automatic write_pool_base(input logic [PPN_W-1:0] base);
        wait_drained();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= base;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        pool_base = base;
    endtask

    task automatic test_edge_addresses();
        // canonical extremes, leaf remap, shared tables
        send_map(64'h0000_0000_0000_0000, 56'h00_0000_0000_0000);
        send_map(64'hFFFF_FFFF_FFFF_FFFF, 56'hFF_FFFF_FFFF_FFFF);
        send_map(64'h0000_003F_FFFF_FFFF, 56'h00_0000_0000_1FFF);
        send_map(64'hFFFF_FFC0_0000_0000, 56'hAA_5555_AAAA_5000);
        send_map(64'h0000_0000_001F_F000, 56'h80_0000_0000_0000);
        send_map(64'h0000_0000_0000_0000, 56'h7F_FFFF_FFFF_F000);
        send_map(64'h0000_0000_3FE0_0000, 56'h12_3456_789A_B000);
        // upper bits not a sign extension of bit 38
        send_map(64'h0000_0040_0000_0000, 56'h00_0000_0000_1000);
        send_map(64'hFFFF_FFBF_FFFF_FFFF, 56'hFF_FFFF_FFFF_FFFF);
        send_map(64'h8000_0000_0000_0000, 56'h55_5555_5555_5555);
        send_map(64'h7FFF_FFFF_FFFF_FFFF, 56'hAA_AAAA_AAAA_AAAA);
        send_map(64'h0000_0080_0000_0000, 56'h00_0000_0000_0000);
    endtask

    // Moving the pool base re-aims existing pointers: some land back inside
    // the pool at another page, the rest fall outside it.
    task automatic test_stray_pointers();
        logic [VA_W-1:0]  probes [4];
        logic [PPN_W-1:0] shifts [2];
        probes = '{64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'h0000_003F_FFFF_F000, 64'hFFFF_FFC0_0000_0000};
        shifts = '{44'd1, 44'd200};
        foreach (shifts[s])
        begin
            write_pool_base(BASE_RESET + shifts[s]);
            foreach (probes[p])
                send_map(probes[p], PA_W'(rand64()));
        end
    endtask

    // Mostly walks through tables already built, with a trickle of fresh
    // branches and malformed addresses.
    task automatic test_random_walks(input int n, input logic [PPN_W-1:0] base,
                                     input bit req_fast, input bit rsp_fast);
        logic [VA_W-1:0] va;
        int              pick;
        write_pool_base(base);
        req_steady = req_fast;
        rsp_steady = rsp_fast;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            va = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
            if (pick < 5)
            begin
                va = rand64();
                if (is_canonical(va))
                    va[63] = ~va[63];
            end
            else if (pick < 7)
                va = canonical_va(39'(rand64()));
            else if (pick < 11)
                va[29:0] = 30'($urandom());
            else
                va[20:0] = 21'($urandom());
            send_map(va, PA_W'(rand64()));
        end
        req_steady = 1'b0;
        rsp_steady = 1'b0;
    endtask

    task automatic test_response_backpressure();
        hold_cycles = HOLD_CYCLES;
        test_random_walks(150, BASE_RESET + 44'd2, 1'b1, 1'b0);
    endtask

    task automatic test_pool_exhaustion();
        logic [VA_W-1:0] va;
        for (int i = 0; i < 24 && pages_taken < TABLE_PAGES; i++)
        begin
            va = mapped_vas[$urandom_range(0, mapped_vas.size() - 1)];
            if (i % 2 == 0)
                va = canonical_va(39'(rand64()));
            else
                va[29:0] = 30'($urandom());
            send_map(va, PA_W'(rand64()));
        end
        repeat (3) send_map(canonical_va(39'(rand64())), PA_W'(rand64()));
    endtask

    initial
    begin : result_check
        int       gap;
        map_rsp_t want;
        forever
        begin
            if (hold_cycles > 0)
            begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            else
                gap = rsp_steady ? 0 : $urandom_range(0, 19);
            @(negedge clk);
            if (gap > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
            if (expected_maps.size() == 0)
            begin
                $display("%0t: unexpected transfer, status %0d leaf_entry %h pages_used %0d",
                         $time, status, leaf_entry, pages_used);
                errors++;
            end
            else
            begin
                want = expected_maps.pop_front();
                if (status !== want.code)
                begin
                    $display("%0t: status expected %0d, actual %0d", $time, want.code, status);
                    errors++;
                end
                if (leaf_entry !== want.leaf)
                begin
                    $display("%0t: leaf_entry expected %h, actual %h",
                             $time, want.leaf, leaf_entry);
                    errors++;
                end
                if (pages_used !== want.used)
                begin
                    $display("%0t: pages_used expected %0d, actual %0d",
                             $time, want.used, pages_used);
                    errors++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        foreach (table_mem[i])
            table_mem[i] = '0;
        pages_taken = 1;
        pool_base   = BASE_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_edge_addresses();
        test_stray_pointers();
        test_random_walks(150, 44'd0, 1'b0, 1'b0);
        test_random_walks(150, 44'hFFF_FFFF_FFFF, 1'b1, 1'b0);
        test_response_backpressure();
        test_random_walks(150, {12'($urandom()), 32'($urandom())}, 1'b0, 1'b1);
        test_random_walks(130, BASE_RESET, 1'b0, 1'b0);
        test_pool_exhaustion();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sv39_page_map_insert.f =====
hdl/sv39pm_pkg.sv
hdl/sv39pm_ctrl.sv
hdl/sv39pm_dp.sv
hdl/sv39_page_map_insert.sv
bench/sv39_page_map_insert_test.sv
